/* hw/rtl/rpr_pkg.sv */
// ----------------------------------------------------------------------------
// rpr_pkg
// Types, constants and field widths shared by the reading-progress ranker.
// ----------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

    localparam int UID_W     = 12;
    localparam int PAGE_W    = 10;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = FRAC_BITS + 1;

    localparam int DEF_MAX_USERS = 4096;
    localparam int DEF_MAX_PAGES = 1000;

    localparam logic [Q_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_CHEER = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_R_DEC,
        ST_R_INC_RD,
        ST_R_INC_WR,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } rpr_state_t;

    typedef enum logic [1:0] {
        HRS_SCAN,
        HRS_PREV,
        HRS_PAGES
    } hist_rsel_t;

    typedef struct packed {
        logic       clear_step;
        logic       accept;
        logic       decide;
        hist_rsel_t hist_rsel;
        logic       hist_dec;
        logic       hist_inc;
        logic       user_wr;
        logic       scan_step;
        logic       div_load;
        logic       div_step;
        logic       out_load;
    } rpr_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic item_drop;
        logic is_read;
        logic prev_known;
        logic cheer_direct;
        logic scan_done;
        logic div_last;
    } rpr_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/rpr_if.sv */
// ----------------------------------------------------------------------------
// rpr_item_if / rpr_result_if
// Valid/ready channels carrying input items and cheer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpr_item_if
    import rpr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [UID_W-1:0]  user_id;
    logic [PAGE_W-1:0] pages_read;

    modport source (output valid, output command, output user_id, output pages_read,
                    input ready);
    modport sink   (input valid, input command, input user_id, input pages_read,
                    output ready);
endinterface

interface rpr_result_if
    import rpr_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] cheer_fraction;

    modport source (output valid, output cheer_fraction, input ready);
    modport sink   (input valid, input cheer_fraction, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rpr_ctrl.sv */
// ----------------------------------------------------------------------------
// rpr_ctrl
// Controller: sequences the clearing pass, read updates, histogram scan,
// serial division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_ctrl
    import rpr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire rpr_stat_t stat,
    output rpr_cmd_t       cmd
);

    rpr_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.item_drop)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.is_read)
                begin
                    if (stat.prev_known)
                    begin
                        cmd.hist_rsel = HRS_PREV;
                        state_next    = ST_R_DEC;
                    end
                    else
                    begin
                        state_next = ST_R_INC_RD;
                    end
                end
                else if (stat.cheer_direct)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_R_DEC:
            begin
                cmd.hist_dec = 1'b1;
                state_next   = ST_R_INC_RD;
            end
            ST_R_INC_RD:
            begin
                cmd.hist_rsel = HRS_PAGES;
                cmd.user_wr   = 1'b1;
                state_next    = ST_R_INC_WR;
            end
            ST_R_INC_WR:
            begin
                cmd.hist_inc = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.hist_rsel = HRS_SCAN;
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/rpr_dp.sv */
// ----------------------------------------------------------------------------
// rpr_dp
// Datapath: per-user page store, page histogram, reader count, histogram
// scan accumulator, restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_dp
    import rpr_pkg::*;
#(
    parameter int MAX_USERS = DEF_MAX_USERS,
    parameter int MAX_PAGES = DEF_MAX_PAGES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              command,
    input  wire logic [UID_W-1:0]  user_id,
    input  wire logic [PAGE_W-1:0] pages_read,
    input  wire rpr_cmd_t          cmd,
    output rpr_stat_t              stat,
    output logic [Q_W-1:0]         cheer_fraction
);

    localparam int UIW   = $clog2(MAX_USERS);
    localparam int HD    = MAX_PAGES + 1;
    localparam int PW    = $clog2(HD);
    localparam int CW    = $clog2(MAX_USERS + 1);
    localparam int CLR_N = (MAX_USERS > HD) ? MAX_USERS : HD;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int NW    = CW + FRAC_BITS;
    localparam int DCW   = $clog2(NW + 1);

    logic [PW-1:0] user_mem [MAX_USERS];
    logic [CW-1:0] hist_mem [HD];

    logic [CLRW-1:0] clr_idx_reg;
    logic [CW-1:0]   total_reg;
    logic            pend_reg;

    logic            cmd_reg;
    logic            uid_ok_reg;
    logic [UIW-1:0]  uid_reg;
    logic [PW-1:0]   pages_reg;
    logic [PW-1:0]   own_reg;
    logic [PW-1:0]   user_rdata_reg;
    logic [CW-1:0]   hist_rdata_reg;
    logic [PW-1:0]   idx_reg;
    logic [CW-1:0]   below_reg;
    logic [CW-1:0]   rem_reg;
    logic [NW-1:0]   dq_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic [Q_W-1:0]  res_reg;
    logic [Q_W-1:0]  frac_reg;

    logic [UID_W+UIW-1:0]  uid_wide;
    logic [PAGE_W+PW-1:0]  pg_wide;
    logic [UIW-1:0]        item_uid;
    logic [PW-1:0]         item_pages;
    logic                  item_uid_ok;
    logic                  item_pages_ok;

    logic [PW-1:0]  hist_raddr;
    logic           hist_we;
    logic [PW-1:0]  hist_waddr;
    logic [CW-1:0]  hist_wdata;
    logic           user_we;
    logic [UIW-1:0] user_waddr;
    logic [PW-1:0]  user_wdata;

    logic           scan_issue;
    logic [CW-1:0]  divisor;
    logic [CW:0]    trial;
    logic [CW:0]    trial_sub;
    logic           fits;
    logic [CW-1:0]  rem_step;
    logic [NW-1:0]  dq_step;

    assign uid_wide      = {{UIW{1'b0}}, user_id};
    assign pg_wide       = {{PW{1'b0}}, pages_read};
    assign item_uid      = uid_wide[UIW-1:0];
    assign item_pages    = pg_wide[PW-1:0];
    assign item_uid_ok   = 32'(user_id) < 32'(MAX_USERS);
    assign item_pages_ok = (pages_read != '0) && (32'(pages_read) <= 32'(MAX_PAGES));

    assign scan_issue = idx_reg != own_reg;
    assign divisor    = total_reg - CW'(1);
    assign trial      = {rem_reg, dq_reg[NW-1]};
    assign trial_sub  = trial - {1'b0, divisor};
    assign fits       = trial >= {1'b0, divisor};
    assign rem_step   = fits ? trial_sub[CW-1:0] : trial[CW-1:0];
    assign dq_step    = {dq_reg[NW-2:0], fits};

    always_comb
    begin
        stat.clear_last   = clr_idx_reg == CLRW'(CLR_N - 1);
        stat.item_drop    = (command == CMD_READ) && !(item_uid_ok && item_pages_ok);
        stat.is_read      = cmd_reg == CMD_READ;
        stat.prev_known   = user_rdata_reg != '0;
        stat.cheer_direct = !uid_ok_reg || (user_rdata_reg == '0) || (total_reg <= CW'(1));
        stat.scan_done    = !scan_issue && !pend_reg;
        stat.div_last     = div_cnt_reg == DCW'(1);
    end

    always_comb
    begin
        unique case (cmd.hist_rsel)
            HRS_PREV:  hist_raddr = user_rdata_reg;
            HRS_PAGES: hist_raddr = pages_reg;
            HRS_SCAN:  hist_raddr = idx_reg;
            default:   hist_raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = own_reg;
        hist_wdata = hist_rdata_reg - CW'(1);
        priority if (cmd.clear_step)
        begin
            hist_we    = 32'(clr_idx_reg) < 32'(HD);
            hist_waddr = clr_idx_reg[PW-1:0];
            hist_wdata = '0;
        end
        else if (cmd.hist_dec)
        begin
            hist_we = hist_rdata_reg != '0;
        end
        else if (cmd.hist_inc)
        begin
            hist_we    = 1'b1;
            hist_waddr = pages_reg;
            hist_wdata = hist_rdata_reg + CW'(1);
        end
        else
        begin
            hist_we = 1'b0;
        end
    end

    always_comb
    begin
        if (cmd.clear_step)
        begin
            user_we    = 32'(clr_idx_reg) < 32'(MAX_USERS);
            user_waddr = clr_idx_reg[UIW-1:0];
            user_wdata = '0;
        end
        else
        begin
            user_we    = cmd.user_wr;
            user_waddr = uid_reg;
            user_wdata = pages_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (user_we)
        begin
            user_mem[user_waddr] <= user_wdata;
        end
        user_rdata_reg <= user_mem[item_uid];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step && !stat.clear_last)
            begin
                clr_idx_reg <= clr_idx_reg + CLRW'(1);
            end
            if (cmd.decide && (cmd_reg == CMD_READ) && (user_rdata_reg == '0))
            begin
                total_reg <= total_reg + CW'(1);
            end
            if (cmd.decide)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= scan_issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg    <= command;
            uid_ok_reg <= item_uid_ok;
            uid_reg    <= item_uid;
            pages_reg  <= item_pages;
        end
        if (cmd.decide)
        begin
            own_reg   <= user_rdata_reg;
            idx_reg   <= PW'(1);
            below_reg <= '0;
            res_reg   <= (!uid_ok_reg || (user_rdata_reg == '0)) ? '0 : FRAC_ONE;
        end
        if (cmd.scan_step)
        begin
            if (scan_issue)
            begin
                idx_reg <= idx_reg + PW'(1);
            end
            if (pend_reg)
            begin
                below_reg <= below_reg + hist_rdata_reg;
            end
        end
        if (cmd.div_load)
        begin
            rem_reg     <= '0;
            dq_reg      <= {below_reg, {FRAC_BITS{1'b0}}};
            div_cnt_reg <= DCW'(NW);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_step;
            dq_reg      <= dq_step;
            div_cnt_reg <= div_cnt_reg - DCW'(1);
            if (stat.div_last)
            begin
                res_reg <= dq_step[Q_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            frac_reg <= res_reg;
        end
    end

    assign cheer_fraction = frac_reg;

endmodule

`default_nettype wire

/* hw/rtl/reader_progress_rank.sv */
// ----------------------------------------------------------------------------
// reader_progress_rank
// Tracks each user's latest page count and answers percentile cheers.
//
// After reset the block runs a clearing pass over its page store and
// histogram, max(MAX_USERS, MAX_PAGES + 1) addresses (4096 at the default
// sizes), and accepts no beat until it ends. A read beat passes through a
// decide state, a decrement of the old histogram bin when the user already
// has a page count, and a read and a write of the new bin before the next
// beat can be taken; a dropped read leaves the block in its idle state. A
// cheer for an unknown user, or while only one user has read, goes from the
// decide state straight to its result. Any other cheer beat sums the
// histogram bins below the user's own page count one bin per cycle through
// its single read port, and the share is formed by a restoring divider that
// retires one quotient bit per cycle. The result sits in an output register,
// so a new beat is accepted while an earlier result still waits to be taken;
// a later cheer holds in its last cycle until that result has gone.
// ----------------------------------------------------------------------------
`default_nettype none

module reader_progress_rank
    import rpr_pkg::*;
#(
    parameter int MAX_USERS = DEF_MAX_USERS,
    parameter int MAX_PAGES = DEF_MAX_PAGES
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rpr_item_if.sink      item,
    rpr_result_if.source  result
);

    rpr_cmd_t  cmd;
    rpr_stat_t stat;

    rpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpr_dp #(
        .MAX_USERS (MAX_USERS),
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (item.command),
        .user_id        (item.user_id),
        .pages_read     (item.pages_read),
        .cmd            (cmd),
        .stat           (stat),
        .cheer_fraction (result.cheer_fraction)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for reader_progress_rank. It sends read and cheer beats through
// the item channel and keeps its own copy of the page store, the histogram
// and the reader count. It predicts each cheer share and checks every result
// beat in order. A directed part covers the corner cases, and random traffic
// on a small pool of users then builds up a large, changing histogram. Both
// channels idle and stall at random, with a stretch that has no idling.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpr_pkg::*;

    localparam int          MAX_PAGES    = DEF_MAX_PAGES;
    localparam int          MAX_USERS    = DEF_MAX_USERS;
    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 1200;

    logic clk;
    logic rst_n;
    bit   no_idle;

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned reads_applied;
    int unsigned reads_dropped;
    int unsigned cheers_checked;

    logic [PAGE_W-1:0] pages_by_user [MAX_USERS];
    int unsigned       readers_at_page [MAX_PAGES+1];
    int unsigned       reader_count;
    logic [Q_W-1:0]    pending_fractions [$];

    rpr_item_if   item_ch ();
    rpr_result_if result_ch ();

    reader_progress_rank uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d cheers outstanding",
                     cycle_count, pending_fractions.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string line);
        $display("MISMATCH at %0t: %s", $realtime, line);
        mismatch_count++;
    endtask

    function automatic void record_read(input logic [UID_W-1:0] uid,
                                        input logic [PAGE_W-1:0] pages);
        logic [PAGE_W-1:0] old_pages;
        if (pages == '0 || pages > MAX_PAGES || uid >= MAX_USERS)
        begin
            reads_dropped++;
            return;
        end
        old_pages = pages_by_user[uid];
        if (old_pages != '0)
        begin
            if (readers_at_page[old_pages] != 0)
                readers_at_page[old_pages]--;
        end
        else
            reader_count++;
        pages_by_user[uid] = pages;
        readers_at_page[pages]++;
        reads_applied++;
    endfunction

    function automatic logic [Q_W-1:0] rank_of_user(input logic [UID_W-1:0] uid);
        int unsigned     own;
        longint unsigned below;
        longint unsigned share;
        if (uid >= MAX_USERS)
            return '0;
        own = pages_by_user[uid];
        if (own == 0 || own > MAX_PAGES)
            return '0;
        if (reader_count <= 1)
            return FRAC_ONE;
        below = 0;
        for (int p = 1; p < own; p++)
            below += readers_at_page[p];
        share = (below << FRAC_BITS) / (reader_count - 1);
        if (share > FRAC_ONE)
            share = FRAC_ONE;
        return Q_W'(share);
    endfunction

    task automatic send_item(input logic cmd, input logic [UID_W-1:0] uid,
                             input logic [PAGE_W-1:0] pages);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.command    <= 1'($urandom);
            item_ch.user_id    <= UID_W'($urandom);
            item_ch.pages_read <= PAGE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= cmd;
        item_ch.user_id    <= uid;
        item_ch.pages_read <= pages;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        if (cmd == CMD_READ)
            record_read(uid, pages);
        else
            pending_fractions.push_back(rank_of_user(uid));
    endtask

    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                @(posedge clk);
                while (result_ch.valid !== 1'b1)
                    @(posedge clk);
                repeat (stall - 1) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        logic [Q_W-1:0] want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_fractions.size() == 0)
                report_mismatch($sformatf("unexpected result beat, cheer_fraction %0d",
                                          result_ch.cheer_fraction));
            else
            begin
                want = pending_fractions.pop_front();
                cheers_checked++;
                if (result_ch.cheer_fraction !== want)
                    report_mismatch($sformatf("cheer_fraction expected %0d, got %0d",
                                              want, result_ch.cheer_fraction));
            end
        end
    end

    task automatic test_empty_store();
        send_item(CMD_CHEER, UID_W'(0), PAGE_W'(0));
        send_item(CMD_CHEER, UID_W'(4095), PAGE_W'(1023));
    endtask

    task automatic test_dropped_reads();
        send_item(CMD_READ, UID_W'(5), PAGE_W'(0));
        send_item(CMD_READ, UID_W'(5), PAGE_W'(1001));
        send_item(CMD_READ, UID_W'(5), PAGE_W'(1023));
        send_item(CMD_CHEER, UID_W'(5), PAGE_W'(512));
    endtask

    task automatic test_sole_reader();
        send_item(CMD_READ, UID_W'(4095), PAGE_W'(MAX_PAGES));
        send_item(CMD_CHEER, UID_W'(4095), PAGE_W'(1023));
    endtask

    task automatic test_repeated_read();
        send_item(CMD_READ, UID_W'(0), PAGE_W'(1));
        send_item(CMD_CHEER, UID_W'(0), PAGE_W'(0));
        send_item(CMD_CHEER, UID_W'(4095), PAGE_W'(0));
        send_item(CMD_READ, UID_W'(0), PAGE_W'(MAX_PAGES));
        send_item(CMD_CHEER, UID_W'(4095), PAGE_W'(0));
    endtask

    task automatic test_uneven_shares();
        send_item(CMD_READ, UID_W'(7), PAGE_W'(500));
        send_item(CMD_READ, UID_W'(9), PAGE_W'(2));
        send_item(CMD_READ, UID_W'(100), PAGE_W'(1));
        send_item(CMD_CHEER, UID_W'(7), PAGE_W'(0));
        send_item(CMD_READ, UID_W'(0), PAGE_W'(2));
        send_item(CMD_READ, UID_W'(11), PAGE_W'(MAX_PAGES - 1));
        send_item(CMD_CHEER, UID_W'(4095), PAGE_W'(0));
        send_item(CMD_CHEER, UID_W'(100), PAGE_W'(0));
    endtask

    task automatic test_random_traffic(input int unsigned target, input bit calm);
        int unsigned       counted;
        int unsigned       pick;
        logic              cmd;
        logic [UID_W-1:0]  uid;
        logic [PAGE_W-1:0] pages;
        no_idle = calm;
        counted = 0;
        while (counted < target)
        begin
            cmd  = ($urandom_range(0, 9) < 4) ? CMD_CHEER : CMD_READ;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                uid = UID_W'($urandom_range(0, 63));
            else if (pick < 8)
                uid = UID_W'($urandom_range(4032, 4095));
            else
                uid = UID_W'($urandom);
            pick = $urandom_range(0, 19);
            if (pick < 15)
                pages = PAGE_W'($urandom_range(1, MAX_PAGES));
            else if (pick < 17)
            begin
                case ($urandom_range(0, 3))
                    0:       pages = PAGE_W'(1);
                    1:       pages = PAGE_W'(2);
                    2:       pages = PAGE_W'(MAX_PAGES - 1);
                    default: pages = PAGE_W'(MAX_PAGES);
                endcase
            end
            else if (pick == 17)
                pages = '0;
            else
                pages = PAGE_W'($urandom_range(MAX_PAGES + 1, 1023));
            send_item(cmd, uid, pages);
            if (cmd == CMD_CHEER || (pages != '0 && pages <= MAX_PAGES))
                counted++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.command    <= CMD_READ;
        item_ch.user_id    <= '0;
        item_ch.pages_read <= '0;
        no_idle        = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        reads_applied  = 0;
        reads_dropped  = 0;
        cheers_checked = 0;
        reader_count   = 0;
        foreach (pages_by_user[u])
            pages_by_user[u] = '0;
        foreach (readers_at_page[p])
            readers_at_page[p] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_dropped_reads();
        test_sole_reader();
        test_repeated_read();
        test_uneven_shares();
        test_random_traffic(185, 1'b0);
        test_random_traffic(110, 1'b1);
        test_random_traffic(185, 1'b0);
        item_ch.valid <= 1'b0;

        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d applied reads, %0d dropped reads and %0d cheer results,",
                 reads_applied, reads_dropped, cheers_checked);
        $display("ending with %0d known readers after %0d cycles and %0d mismatches.",
                 reader_count, cycle_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_if.sv
hw/rtl/rpr_ctrl.sv
hw/rtl/rpr_dp.sv
hw/rtl/reader_progress_rank.sv
test/tb_top.sv
